// ===== rtl/core/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

  // Result kinds as seen on the output ports
  typedef enum logic [2:0] {
    KIND_DATA       = 3'd0,
    KIND_PING       = 3'd1,
    KIND_TOO_LARGE  = 3'd2,
    KIND_CLOSE      = 3'd3,
    KIND_EMPTY_PING = 3'd4
  } kind_e;

  // Header parse positions
  localparam logic [3:0] STEP_IDLE        = 4'd0;
  localparam logic [3:0] STEP_LEN7        = 4'd1;
  localparam logic [3:0] STEP_EXT16_FIRST = 4'd2;
  localparam logic [3:0] STEP_EXT16_LAST  = 4'd3;
  localparam logic [3:0] STEP_EXT64_FIRST = 4'd4;
  localparam logic [3:0] STEP_EXT64_LAST  = 4'd11;
  localparam logic [3:0] STEP_KEY_FIRST   = 4'd12;
  localparam logic [3:0] STEP_KEY_SECOND  = 4'd13;
  localparam logic [3:0] STEP_KEY_THIRD   = 4'd14;
  localparam logic [3:0] STEP_KEY_LAST    = 4'd15;

  localparam logic [3:0] OPCODE_MASK  = 4'hf;
  localparam logic [3:0] OP_BINARY    = 4'h2;
  localparam logic [3:0] OP_CLOSE     = 4'h8;
  localparam logic [3:0] OP_PING      = 4'h9;

  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;

  localparam logic [31:0] MAX_LEN_RESET = 32'd2097152;

  // Classified byte handed from the parser to the unmask stage
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } cmd_t;

  // Finished result
  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/wsd_front.sv =====
`timescale 1ns / 1ps

module wsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           cfg_valid_i,
  input  logic [31:0]    cfg_data_i,
  output logic           cmd_valid_o,
  output wsd_pkg::cmd_t  cmd_o
);

  logic [31:0] max_len_q;
  logic [3:0]  step_q, step_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] key_q, key_d;
  logic [31:0] left_q, left_d;
  logic [1:0]  phase_q, phase_d;
  logic        halted_q, halted_d;

  logic [63:0] acc_shift;
  logic [63:0] len_val;
  logic [31:0] left_dec;
  logic [6:0]  len7;
  logic        do_len;
  logic        do_done;
  logic        too_large;

  assign acc_shift = {acc_q[55:0], in_byte_i};
  assign left_dec  = left_q - 32'd1;
  assign len7      = in_byte_i[6:0];

  always_comb begin
    step_d      = step_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    acc_d       = acc_q;
    key_d       = key_q;
    left_d      = left_q;
    phase_d     = phase_q;
    halted_d    = halted_q;
    do_len      = 1'b0;
    do_done     = 1'b0;
    len_val     = acc_shift;
    too_large   = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = wsd_pkg::KIND_DATA;
    cmd_o.data  = 8'h00;
    cmd_o.key   = 8'h00;
    cmd_o.last  = 1'b0;

    if (in_valid_i && !halted_q) begin
      case (step_q)
        wsd_pkg::STEP_IDLE: begin
          if (left_q != 32'd0) begin
            left_d     = left_dec;
            cmd_o.last = (left_dec == 32'd0);
            if (opcode_q <= wsd_pkg::OP_BINARY) begin
              cmd_valid_o = 1'b1;
              cmd_o.kind  = wsd_pkg::KIND_DATA;
              cmd_o.data  = in_byte_i;
              cmd_o.key   = mask_q ? key_q[{phase_q, 3'b000} +: 8] : 8'h00;
              phase_d     = phase_q + 2'd1;
            end else if (opcode_q == wsd_pkg::OP_PING) begin
              cmd_valid_o = 1'b1;
              cmd_o.kind  = wsd_pkg::KIND_PING;
              cmd_o.data  = in_byte_i;
            end else if (opcode_q == wsd_pkg::OP_CLOSE && left_dec == 32'd0) begin
              halted_d    = 1'b1;
              cmd_valid_o = 1'b1;
              cmd_o.kind  = wsd_pkg::KIND_CLOSE;
            end
          end else begin
            opcode_d = in_byte_i[3:0] & wsd_pkg::OPCODE_MASK;
            step_d   = wsd_pkg::STEP_LEN7;
          end
        end
        wsd_pkg::STEP_LEN7: begin
          mask_d = in_byte_i[7];
          key_d  = 32'd0;
          acc_d  = 64'd0;
          if (len7 == wsd_pkg::LEN7_EXT16) begin
            step_d = wsd_pkg::STEP_EXT16_FIRST;
          end else if (len7 == wsd_pkg::LEN7_EXT64) begin
            step_d = wsd_pkg::STEP_EXT64_FIRST;
          end else begin
            acc_d   = {57'd0, len7};
            len_val = {57'd0, len7};
            do_len  = 1'b1;
          end
        end
        wsd_pkg::STEP_EXT16_LAST, wsd_pkg::STEP_EXT64_LAST: begin
          acc_d  = acc_shift;
          do_len = 1'b1;
        end
        wsd_pkg::STEP_KEY_FIRST, wsd_pkg::STEP_KEY_SECOND, wsd_pkg::STEP_KEY_THIRD: begin
          key_d[{step_q[1:0], 3'b000} +: 8] = in_byte_i;
          step_d = step_q + 4'd1;
        end
        wsd_pkg::STEP_KEY_LAST: begin
          key_d[31:24] = in_byte_i;
          do_done      = 1'b1;
        end
        default: begin
          // intermediate extended length bytes
          acc_d  = acc_shift;
          step_d = step_q + 4'd1;
        end
      endcase

      if (do_len) begin
        too_large = (|len_val[63:32]) || (len_val[31:0] > max_len_q);
        if (too_large) begin
          halted_d    = 1'b1;
          cmd_valid_o = 1'b1;
          cmd_o.kind  = wsd_pkg::KIND_TOO_LARGE;
        end else begin
          left_d  = len_val[31:0];
          phase_d = 2'd0;
          if (mask_d) begin
            step_d = wsd_pkg::STEP_KEY_FIRST;
          end else begin
            do_done = 1'b1;
          end
        end
      end

      // header complete: an empty close or ping ends here
      if (do_done) begin
        step_d = wsd_pkg::STEP_IDLE;
        if (left_d == 32'd0) begin
          if (opcode_q == wsd_pkg::OP_CLOSE) begin
            halted_d    = 1'b1;
            cmd_valid_o = 1'b1;
            cmd_o.kind  = wsd_pkg::KIND_CLOSE;
            cmd_o.last  = 1'b1;
          end else if (opcode_q == wsd_pkg::OP_PING) begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = wsd_pkg::KIND_EMPTY_PING;
            cmd_o.last  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= wsd_pkg::MAX_LEN_RESET;
      step_q    <= wsd_pkg::STEP_IDLE;
      opcode_q  <= 4'd0;
      mask_q    <= 1'b0;
      acc_q     <= 64'd0;
      key_q     <= 32'd0;
      left_q    <= 32'd0;
      phase_q   <= 2'd0;
      halted_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
      step_q   <= step_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      acc_q    <= acc_d;
      key_q    <= key_d;
      left_q   <= left_d;
      phase_q  <= phase_d;
      halted_q <= halted_d;
    end
  end

`ifndef ASSERT_OFF
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_halt_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !cmd_valid_o)
    else $error("command issued while halted");

  a_error_halts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && (cmd_o.kind == wsd_pkg::KIND_TOO_LARGE ||
                     cmd_o.kind == wsd_pkg::KIND_CLOSE)) |=> halted_q)
    else $error("error result did not halt the parser");
`endif

endmodule

// ===== rtl/core/wsd_cmd_queue.sv =====
`timescale 1ns / 1ps

module wsd_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output wsd_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  wsd_pkg::cmd_t entry_q [2];
  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic          do_push;
  logic          do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

// ===== rtl/core/wsd_back.sv =====
`timescale 1ns / 1ps

module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  wsd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output wsd_pkg::res_t res_o
);

  wsd_pkg::res_t res_q [2];
  wsd_pkg::res_t res_new;
  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic          res_full;
  logic          do_pop;

  assign res_full  = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign cmd_pop_o = cmd_valid_i && !res_full;
  assign do_pop    = pop_i && !empty_o;
  assign res_o     = res_q[rd_ptr_q];

  // unmask: key is zero for unmasked data, pings and events
  always_comb begin
    res_new.kind    = cmd_i.kind;
    res_new.payload = cmd_i.data ^ cmd_i.key;
    res_new.last    = cmd_i.last;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_pop_o && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !cmd_pop_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_pop_o) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

// ===== rtl/core/websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// WebSocket receive deframer: one stream byte is taken per cycle whenever full is low. A
// header parser classifies each byte in the cycle it arrives (opcode, mask bit, 7/16/64-bit
// length, mask key) and hands payload bytes and events through a two-entry command queue to an
// unmask stage, which writes finished results into a two-entry output queue; a byte that causes
// a result is registered in the command queue, then unmasked and registered in the output
// queue, whose head is on the output ports; the sustained rate is one byte per cycle while full
// stays low, set by the parser step. Data bytes (opcodes 0 to 2) come out unmasked, ping bytes
// raw, an empty ping as a marker. An oversized length or a close frame gives an error result,
// after which input bytes are still taken but ignored until reset. The length limit is written
// over the cfg port, which is always ready; write it only when idle.
module websocket_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_in_frame_o
);

  wsd_pkg::cmd_t front_cmd;
  wsd_pkg::cmd_t queue_cmd;
  wsd_pkg::res_t res;
  logic          front_valid;
  logic          queue_empty;
  logic          queue_pop;
  logic          in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = push && !full;

  wsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_accept),
    .in_byte_i   (stream_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  wsd_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_cmd),
    .full_o      (full),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_cmd),
    .empty_o     (queue_empty)
  );

  wsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign payload_byte_o  = res.payload;
  assign last_in_frame_o = res.last;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_QUIET,
    ROW_RESULT
  } row_e;

  typedef struct packed {
    logic [7:0]    data;
    row_e          how;
    wsd_pkg::res_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  stream_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data = 32'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        last_in_frame_o;

  // Deframer state mirrored for prediction
  logic [3:0]  hdr_step = wsd_pkg::STEP_IDLE;
  logic [3:0]  fr_op = 4'h0;
  bit          fr_masked = 1'b0;
  logic [63:0] len_acc = 64'd0;
  logic [31:0] key = 32'd0;
  logic [31:0] remaining = 32'd0;
  logic [1:0]  key_phase = 2'd0;
  bit          stopped = 1'b0;
  logic [31:0] frame_limit = wsd_pkg::MAX_LEN_RESET;

  wsd_pkg::res_t due_results[$];
  int            bad_count = 0;
  int unsigned   bytes_sent = 0;
  bit            send_calm = 1'b0;
  bit            take_calm = 1'b0;

  // Directed opening: 16-bit length text, masked binary, empty ping, masked ping
  // with RSV set and FIN clear, empty pong. Reset length limit in force.
  script_row_t script [25] = '{
    '{8'h81, ROW_QUIET, '0}, '{8'h7E, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0}, '{8'h02, ROW_QUIET, '0},
    '{8'h00, ROW_RESULT, '{wsd_pkg::KIND_DATA, 8'h00, 1'b0}},
    '{8'hFF, ROW_RESULT, '{wsd_pkg::KIND_DATA, 8'hFF, 1'b1}},
    '{8'h82, ROW_QUIET, '0}, '{8'h82, ROW_QUIET, '0},
    '{8'h11, ROW_QUIET, '0}, '{8'h22, ROW_QUIET, '0},
    '{8'h44, ROW_QUIET, '0}, '{8'h88, ROW_QUIET, '0},
    '{8'hFF, ROW_MODEL, '0}, '{8'h00, ROW_MODEL, '0},
    '{8'h89, ROW_QUIET, '0},
    '{8'h00, ROW_RESULT, '{wsd_pkg::KIND_EMPTY_PING, 8'h00, 1'b1}},
    '{8'h79, ROW_QUIET, '0}, '{8'h81, ROW_QUIET, '0},
    '{8'hA5, ROW_QUIET, '0}, '{8'h5A, ROW_QUIET, '0},
    '{8'h0F, ROW_QUIET, '0}, '{8'hF0, ROW_QUIET, '0},
    '{8'hC3, ROW_RESULT, '{wsd_pkg::KIND_PING, 8'hC3, 1'b1}},
    '{8'h8A, ROW_QUIET, '0}, '{8'h00, ROW_QUIET, '0}
  };

  websocket_frame_deframer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .stream_byte_i   (stream_byte),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .last_in_frame_o (last_in_frame_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Header complete: an empty close or ping ends the frame here
  function automatic bit header_end(output wsd_pkg::res_t r);
    r = '0;
    hdr_step = wsd_pkg::STEP_IDLE;
    if (remaining != 0) return 1'b0;
    if (fr_op == wsd_pkg::OP_CLOSE) begin
      stopped = 1'b1;
      r = '{wsd_pkg::KIND_CLOSE, 8'h00, 1'b1};
      return 1'b1;
    end
    if (fr_op == wsd_pkg::OP_PING) begin
      r = '{wsd_pkg::KIND_EMPTY_PING, 8'h00, 1'b1};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit length_end(output wsd_pkg::res_t r);
    r = '0;
    if (len_acc > {32'd0, frame_limit}) begin
      stopped = 1'b1;
      r = '{wsd_pkg::KIND_TOO_LARGE, 8'h00, 1'b0};
      return 1'b1;
    end
    remaining = len_acc[31:0];
    key_phase = 2'd0;
    if (fr_masked) begin
      hdr_step = wsd_pkg::STEP_KEY_FIRST;
      return 1'b0;
    end
    return header_end(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output wsd_pkg::res_t r);
    bit         ends;
    logic [7:0] k;
    r = '0;
    if (stopped) return 1'b0;
    case (hdr_step)
      wsd_pkg::STEP_IDLE: begin
        if (remaining != 0) begin
          remaining--;
          ends = (remaining == 0);
          if (fr_op <= wsd_pkg::OP_BINARY) begin
            k = fr_masked ? key[8 * key_phase +: 8] : 8'h00;
            key_phase++;
            r = '{wsd_pkg::KIND_DATA, b ^ k, ends};
            return 1'b1;
          end
          if (fr_op == wsd_pkg::OP_PING) begin
            r = '{wsd_pkg::KIND_PING, b, ends};
            return 1'b1;
          end
          if (fr_op == wsd_pkg::OP_CLOSE && ends) begin
            stopped = 1'b1;
            r = '{wsd_pkg::KIND_CLOSE, 8'h00, 1'b1};
            return 1'b1;
          end
          return 1'b0;
        end
        fr_op = b[3:0] & wsd_pkg::OPCODE_MASK;
        hdr_step = wsd_pkg::STEP_LEN7;
        return 1'b0;
      end
      wsd_pkg::STEP_LEN7: begin
        fr_masked = b[7];
        key = 32'd0;
        len_acc = 64'd0;
        if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
          hdr_step = wsd_pkg::STEP_EXT16_FIRST;
          return 1'b0;
        end
        if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
          hdr_step = wsd_pkg::STEP_EXT64_FIRST;
          return 1'b0;
        end
        len_acc = {57'd0, b[6:0]};
        return length_end(r);
      end
      wsd_pkg::STEP_EXT16_LAST, wsd_pkg::STEP_EXT64_LAST: begin
        len_acc = {len_acc[55:0], b};
        return length_end(r);
      end
      wsd_pkg::STEP_KEY_FIRST, wsd_pkg::STEP_KEY_SECOND, wsd_pkg::STEP_KEY_THIRD: begin
        key[8 * (hdr_step - wsd_pkg::STEP_KEY_FIRST) +: 8] = b;
        hdr_step++;
        return 1'b0;
      end
      wsd_pkg::STEP_KEY_LAST: begin
        key[31:24] = b;
        return header_end(r);
      end
      default: begin
        len_acc = {len_acc[55:0], b};
        hdr_step++;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input row_e how = ROW_MODEL,
                           input wsd_pkg::res_t want = '0);
    wsd_pkg::res_t got;
    bit            has;
    int unsigned   gap;
    gap = pick_gap(send_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push = 1'b1;
    stream_byte = b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    has = deframe_byte(b, got);
    if (how == ROW_RESULT) begin
      due_results.push_back(want);
    end else if (how == ROW_MODEL && has) begin
      due_results.push_back(got);
    end
  endtask

  // enc: 0 for 7-bit length, 1 for 16-bit, 2 for 64-bit
  task automatic send_frame(input logic [3:0] op, input logic [63:0] len,
                            input int unsigned enc, input bit mask);
    logic [3:0]  hi;
    logic [63:0] n;
    if (enc == 0 && len > 125) enc = 1;
    if (enc == 1 && len > 64'hFFFF) enc = 2;
    hi = 4'($urandom());
    send_byte({hi, op});
    case (enc)
      0: send_byte({mask, len[6:0]});
      1: begin
        send_byte({mask, wsd_pkg::LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, wsd_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    // oversized length or empty close has already halted the block
    if (stopped) return;
    if (mask) repeat (4) send_byte(8'($urandom()));
    for (n = 64'd0; n < len; n++) send_byte(8'($urandom()));
  endtask

  task automatic send_random_frame();
    logic [3:0]  op;
    logic [31:0] len;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      op = 4'($urandom_range(0, 2));
    end else if (roll < 75) begin
      op = wsd_pkg::OP_PING;
    end else begin
      op = 4'($urandom_range(3, 15));
      while (op == wsd_pkg::OP_CLOSE || op == wsd_pkg::OP_PING)
        op = 4'($urandom_range(3, 15));
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) len = $urandom_range(0, 8);
    else if (roll < 95) len = $urandom_range(9, 40);
    else len = $urandom_range(100, 300);
    if (len > frame_limit) len = frame_limit;
    roll = $urandom_range(0, 9);
    send_frame(op, {32'd0, len}, (roll < 6) ? 0 : $urandom_range(1, 2),
               1'($urandom_range(0, 1)));
  endtask

  // Drop push and hold until every expected transfer is out (or a guard expires) and the pipe is quiet
  task automatic settle();
    int unsigned guard;
    @(negedge clk_i);
    push = 1'b0;
    guard = 0;
    while (due_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_limit = value;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  initial begin : take_side
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        stall = pick_gap(take_calm);
        pop = (stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    wsd_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (due_results.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("[%0t] unexpected result: kind %0d byte %02h last %0b",
                   $time, kind_o, payload_byte_o, last_in_frame_o);
      end else begin
        want = due_results.pop_front();
        if (kind_o !== want.kind || payload_byte_o !== want.payload ||
            last_in_frame_o !== want.last) begin
          bad_count++;
          if (bad_count <= 10)
            $display("[%0t] result differs: expected kind %0d byte %02h last %0b,",
                     $time, want.kind, want.payload, want.last,
                     " got kind %0d byte %02h last %0b",
                     kind_o, payload_byte_o, last_in_frame_o);
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] phase_limits [6];
    logic [31:0] end_limit;
    int unsigned phase_end;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) send_byte(script[i].data, script[i].how, script[i].want);
    settle();

    phase_limits = '{32'hFFFF_FFFF, 32'd0, 32'd1, wsd_pkg::MAX_LEN_RESET,
                     32'($urandom_range(2, 40)), $urandom()};
    foreach (phase_limits[p]) begin
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      set_limit(phase_limits[p]);
      phase_end = bytes_sent + 55;
      while (bytes_sent < phase_end) send_random_frame();
      settle();
    end

    // One terminating error per run, since only reset clears the halt
    send_calm = 1'b0;
    take_calm = 1'b0;
    end_limit = $urandom_range(0, 20);
    set_limit(end_limit);
    case ($urandom_range(0, 4))
      0: send_frame(wsd_pkg::OP_CLOSE, 64'd0, $urandom_range(0, 2),
                    1'($urandom_range(0, 1)));
      1: send_frame(wsd_pkg::OP_CLOSE,
                    (end_limit == 0) ? 64'd0 : 64'($urandom_range(1, end_limit)),
                    $urandom_range(0, 2), 1'($urandom_range(0, 1)));
      2: send_frame(wsd_pkg::OP_CLOSE, 64'(end_limit) + 64'($urandom_range(1, 200)),
                    $urandom_range(0, 2), 1'($urandom_range(0, 1)));
      3: send_frame(4'($urandom_range(0, 2)),
                    {$urandom(), $urandom()} | 64'h0100_0000_0000_0000, 2,
                    1'($urandom_range(0, 1)));
      default: send_frame(($urandom_range(0, 1) == 0) ? wsd_pkg::OP_PING
                                                      : 4'($urandom_range(0, 2)),
                          64'(end_limit) + 64'($urandom_range(1, 200)),
                          $urandom_range(0, 2), 1'($urandom_range(0, 1)));
    endcase
    // halted: these must vanish without a result
    repeat (12) send_byte(8'($urandom()));
    settle();

    if (due_results.size() != 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0d expected results never arrived", due_results.size());
    end
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wsd_pkg.sv
rtl/core/wsd_front.sv
rtl/core/wsd_cmd_queue.sv
rtl/core/wsd_back.sv
rtl/core/websocket_frame_deframer_unit.sv
bench/tb_top.sv
